[hw/rtl/scc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, register codes and angle constants for sphere/cone culling.
// No dependencies; used by the CORDIC cell module and by the top level.
package scc_pkg;

    localparam int DEFAULT_ANGLE_ITERATIONS = 16;

    localparam int POS_W   = 32;
    localparam int OFS_W   = 33;
    localparam int EXT_W   = 31;
    localparam int FACE_W  = 16;
    localparam int RANGE_W = 31;
    localparam int HALF_W  = 16;

    localparam int SQR_W   = 64;
    localparam int PRD_W   = 49;
    localparam int DOT_W   = 51;
    localparam int ROOT1_W = 33;
    localparam int DIVD_W  = 65;
    localparam int QUO_W   = 30;
    localparam int FRAC_W  = 29;
    localparam int ROOT2_W = 29;
    localparam int ANG_W   = 34;

    localparam logic [FRAC_W-1:0] ONE_Q28 = FRAC_W'(1) << 28;
    localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [32] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,
        34'sd64,        34'sd32,        34'sd16,        34'sd8,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

    typedef enum logic [2:0] {
        REG_EYE_X      = 3'd0,
        REG_EYE_Y      = 3'd1,
        REG_EYE_Z      = 3'd2,
        REG_FACING_X   = 3'd3,
        REG_FACING_Y   = 3'd4,
        REG_FACING_Z   = 3'd5,
        REG_VIEW_RANGE = 3'd6,
        REG_HALF_CONE  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic                    hidden;
    } front_t;

    typedef struct packed {
        logic far;
        logic early;
        logic hidden;
        logic cneg;
    } flags_t;

    typedef struct packed {
        flags_t            flags;
        logic [FRAC_W-1:0] cmag;
        logic [FRAC_W-1:0] sval;
    } mid_t;

endpackage

[hw/rtl/scc_sqrt_cell.sv]
`timescale 1ns / 1ps
// One digit step of a two-lane restoring square root, with a passing tag.
// Depends on nothing; chained by the top level.
module scc_sqrt_cell #(
    parameter int HALF  = 33,
    parameter int TAG_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [TAG_W-1:0]    in_tag,
    input  logic [2*HALF-1:0]   in_op   [2],
    input  logic [HALF+1:0]     in_rem  [2],
    input  logic [HALF-1:0]     in_root [2],
    output logic                out_valid,
    output logic [TAG_W-1:0]    out_tag,
    output logic [2*HALF-1:0]   out_op   [2],
    output logic [HALF+1:0]     out_rem  [2],
    output logic [HALF-1:0]     out_root [2]
);

    logic              valid_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [2*HALF-1:0] op_reg   [2];
    logic [2*HALF-1:0] op_next  [2];
    logic [HALF+1:0]   rem_reg  [2];
    logic [HALF+1:0]   rem_next [2];
    logic [HALF-1:0]   root_reg [2];
    logic [HALF-1:0]   root_next[2];
    logic [HALF+1:0]   cand     [2];
    logic [HALF+1:0]   trial    [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            cand[l]    = {in_rem[l][HALF-1:0], in_op[l][2*HALF-1 -: 2]};
            trial[l]   = {in_root[l], 2'b01};
            op_next[l] = {in_op[l][2*HALF-3:0], 2'b00};
            if (cand[l] >= trial[l])
            begin
                rem_next[l]  = cand[l] - trial[l];
                root_next[l] = {in_root[l][HALF-2:0], 1'b1};
            end
            else
            begin
                rem_next[l]  = cand[l];
                root_next[l] = {in_root[l][HALF-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= in_tag;
        for (int l = 0; l < 2; l++)
        begin
            op_reg[l]   <= op_next[l];
            rem_reg[l]  <= rem_next[l];
            root_reg[l] <= root_next[l];
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_op    = op_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

[hw/rtl/scc_div_cell.sv]
`timescale 1ns / 1ps
// One quotient bit of a two-lane restoring divider sharing one divisor, with a tag.
// Depends on nothing; chained by the top level.
module scc_div_cell #(
    parameter int DW    = 65,
    parameter int VW    = 33,
    parameter int QW    = 30,
    parameter int BIT   = 29,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [TAG_W-1:0] in_tag,
    input  logic [VW-1:0]    in_div,
    input  logic [DW-1:0]    in_rem [2],
    input  logic [QW-1:0]    in_quo [2],
    output logic             out_valid,
    output logic [TAG_W-1:0] out_tag,
    output logic [VW-1:0]    out_div,
    output logic [DW-1:0]    out_rem [2],
    output logic [QW-1:0]    out_quo [2]
);

    logic             valid_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [VW-1:0]    div_reg;
    logic [DW-1:0]    rem_reg  [2];
    logic [DW-1:0]    rem_next [2];
    logic [QW-1:0]    quo_reg  [2];
    logic [QW-1:0]    quo_next [2];
    logic [DW-1:0]    shifted;

    assign shifted = DW'(in_div) << BIT;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (in_rem[l] >= shifted)
            begin
                rem_next[l] = in_rem[l] - shifted;
                quo_next[l] = {in_quo[l][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = in_rem[l];
                quo_next[l] = {in_quo[l][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= in_tag;
        div_reg <= in_div;
        for (int l = 0; l < 2; l++)
        begin
            rem_reg[l] <= rem_next[l];
            quo_reg[l] <= quo_next[l];
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_div   = div_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

[hw/rtl/scc_cordic_cell.sv]
`timescale 1ns / 1ps
// One vectoring CORDIC rotation for two lanes, with a passing tag.
// Depends on scc_pkg for the arctangent table and angle width.
module scc_cordic_cell #(
    parameter int IDX   = 0,
    parameter int TAG_W = 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [TAG_W-1:0]                      in_tag,
    input  logic signed [scc_pkg::ANG_W-1:0]      in_x [2],
    input  logic signed [scc_pkg::ANG_W-1:0]      in_y [2],
    input  logic signed [scc_pkg::ANG_W-1:0]      in_z [2],
    output logic                                  out_valid,
    output logic [TAG_W-1:0]                      out_tag,
    output logic signed [scc_pkg::ANG_W-1:0]      out_x [2],
    output logic signed [scc_pkg::ANG_W-1:0]      out_y [2],
    output logic signed [scc_pkg::ANG_W-1:0]      out_z [2]
);

    logic                             valid_reg;
    logic [TAG_W-1:0]                 tag_reg;
    logic signed [scc_pkg::ANG_W-1:0] x_reg  [2];
    logic signed [scc_pkg::ANG_W-1:0] y_reg  [2];
    logic signed [scc_pkg::ANG_W-1:0] z_reg  [2];
    logic signed [scc_pkg::ANG_W-1:0] x_next [2];
    logic signed [scc_pkg::ANG_W-1:0] y_next [2];
    logic signed [scc_pkg::ANG_W-1:0] z_next [2];
    logic signed [scc_pkg::ANG_W-1:0] dx     [2];
    logic signed [scc_pkg::ANG_W-1:0] dy     [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            dx[l] = in_y[l] >>> IDX;
            dy[l] = in_x[l] >>> IDX;
            if (!in_y[l][scc_pkg::ANG_W-1])
            begin
                x_next[l] = in_x[l] + dx[l];
                y_next[l] = in_y[l] - dy[l];
                z_next[l] = in_z[l] + scc_pkg::ATAN_TAB[IDX];
            end
            else
            begin
                x_next[l] = in_x[l] - dx[l];
                y_next[l] = in_y[l] + dy[l];
                z_next[l] = in_z[l] - scc_pkg::ATAN_TAB[IDX];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= in_tag;
        for (int l = 0; l < 2; l++)
        begin
            x_reg[l] <= x_next[l];
            y_reg[l] <= y_next[l];
            z_reg[l] <= z_next[l];
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

[hw/rtl/sphere_cone_range_culling.sv]
`timescale 1ns / 1ps
// Top level of sphere and cone range culling: config registers, arithmetic front end,
// and chains of scc_sqrt_cell, scc_div_cell and scc_cordic_cell. Depends on scc_pkg.
//
// Usage:
//   Set eye, facing, view_range and half_cone through the APB port while no object is
//   in flight. Present one object per cycle on center_*/extent_*/hidden with start high;
//   busy is always low, so every start is taken and a new object may follow each cycle.
//   Each transaction produces exactly one result: done is high for one cycle with far
//   and seen valid. On its way to done an object passes the front-end registers, 33
//   cells for the distance and radius roots, the divider setup register, 30 divider
//   cells, the clamp registers, 29 cells for the sine roots, one CORDIC cell per
//   iteration and the result register. Throughput is one object per cycle.
//   Results are never held: the receiver must take done when it appears.
//   Reset clears all in-flight transactions and loads the register defaults
//   (facing = +z, range unlimited, cone disabled).
module sphere_cone_range_culling #(
    parameter int ANGLE_ITERATIONS = scc_pkg::DEFAULT_ANGLE_ITERATIONS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [scc_pkg::POS_W-1:0]    center_x,
    input  logic signed [scc_pkg::POS_W-1:0]    center_y,
    input  logic signed [scc_pkg::POS_W-1:0]    center_z,
    input  logic [scc_pkg::EXT_W-1:0]           extent_x,
    input  logic [scc_pkg::EXT_W-1:0]           extent_y,
    input  logic [scc_pkg::EXT_W-1:0]           extent_z,
    input  logic                                hidden,
    output logic                                done,
    output logic                                far,
    output logic                                seen,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int SQ1_N  = scc_pkg::ROOT1_W;
    localparam int SQ2_N  = scc_pkg::ROOT2_W;
    localparam int DIV_N  = scc_pkg::QUO_W;
    localparam int FW     = $bits(scc_pkg::front_t);
    localparam int GW     = $bits(scc_pkg::flags_t);
    localparam int MW     = $bits(scc_pkg::mid_t);
    localparam int AW     = scc_pkg::ANG_W;

    // ---------------- configuration ----------------
    logic signed [scc_pkg::POS_W-1:0]  eye_x_reg, eye_y_reg, eye_z_reg;
    logic signed [scc_pkg::FACE_W-1:0] facing_x_reg, facing_y_reg, facing_z_reg;
    logic [scc_pkg::RANGE_W-1:0]       view_range_reg;
    logic [scc_pkg::HALF_W-1:0]        half_cone_reg;
    logic                              cfg_write;
    scc_pkg::cfg_reg_t                 cfg_sel;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = scc_pkg::cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg      <= '0;
            eye_y_reg      <= '0;
            eye_z_reg      <= '0;
            facing_x_reg   <= '0;
            facing_y_reg   <= '0;
            facing_z_reg   <= 16'sd16384;
            view_range_reg <= '0;
            half_cone_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                scc_pkg::REG_EYE_X:      eye_x_reg      <= pwdata;
                scc_pkg::REG_EYE_Y:      eye_y_reg      <= pwdata;
                scc_pkg::REG_EYE_Z:      eye_z_reg      <= pwdata;
                scc_pkg::REG_FACING_X:   facing_x_reg   <= pwdata[15:0];
                scc_pkg::REG_FACING_Y:   facing_y_reg   <= pwdata[15:0];
                scc_pkg::REG_FACING_Z:   facing_z_reg   <= pwdata[15:0];
                scc_pkg::REG_VIEW_RANGE: view_range_reg <= pwdata[30:0];
                scc_pkg::REG_HALF_CONE:  half_cone_reg  <= pwdata[15:0];
                default:                 half_cone_reg  <= half_cone_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            scc_pkg::REG_EYE_X:      prdata = eye_x_reg;
            scc_pkg::REG_EYE_Y:      prdata = eye_y_reg;
            scc_pkg::REG_EYE_Z:      prdata = eye_z_reg;
            scc_pkg::REG_FACING_X:   prdata = {16'b0, facing_x_reg};
            scc_pkg::REG_FACING_Y:   prdata = {16'b0, facing_y_reg};
            scc_pkg::REG_FACING_Z:   prdata = {16'b0, facing_z_reg};
            scc_pkg::REG_VIEW_RANGE: prdata = {1'b0, view_range_reg};
            scc_pkg::REG_HALF_CONE:  prdata = {16'b0, half_cone_reg};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- front end: offsets, squares, sums ----------------
    logic                               p1_valid_reg;
    logic signed [scc_pkg::OFS_W-1:0]   tx_reg, ty_reg, tz_reg;
    logic [scc_pkg::EXT_W-1:0]          ex_reg, ey_reg, ez_reg;
    logic                               p1_hid_reg;

    logic                               p2_valid_reg;
    logic [scc_pkg::SQR_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [2*scc_pkg::EXT_W-1:0]        sex_reg, sey_reg, sez_reg;
    logic signed [scc_pkg::PRD_W-1:0]   px_reg, py_reg, pz_reg;
    logic                               p2_hid_reg;

    logic                               p3_valid_reg;
    logic [2*SQ1_N-1:0]                 d2_reg, r2_reg;
    scc_pkg::front_t                    p3_front_reg;

    logic signed [2*scc_pkg::OFS_W-1:0] sqx_full, sqy_full, sqz_full;
    logic signed [scc_pkg::PRD_W-1:0]   px_full, py_full, pz_full;

    assign sqx_full = tx_reg * tx_reg;
    assign sqy_full = ty_reg * ty_reg;
    assign sqz_full = tz_reg * tz_reg;
    assign px_full  = tx_reg * facing_x_reg;
    assign py_full  = ty_reg * facing_y_reg;
    assign pz_full  = tz_reg * facing_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= start && !busy;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg     <= scc_pkg::OFS_W'(center_x) - scc_pkg::OFS_W'(eye_x_reg);
        ty_reg     <= scc_pkg::OFS_W'(center_y) - scc_pkg::OFS_W'(eye_y_reg);
        tz_reg     <= scc_pkg::OFS_W'(center_z) - scc_pkg::OFS_W'(eye_z_reg);
        ex_reg     <= extent_x;
        ey_reg     <= extent_y;
        ez_reg     <= extent_z;
        p1_hid_reg <= hidden;

        sqx_reg    <= sqx_full[scc_pkg::SQR_W-1:0];
        sqy_reg    <= sqy_full[scc_pkg::SQR_W-1:0];
        sqz_reg    <= sqz_full[scc_pkg::SQR_W-1:0];
        sex_reg    <= ex_reg * ex_reg;
        sey_reg    <= ey_reg * ey_reg;
        sez_reg    <= ez_reg * ez_reg;
        px_reg     <= px_full;
        py_reg     <= py_full;
        pz_reg     <= pz_full;
        p2_hid_reg <= p1_hid_reg;

        d2_reg <= (2*SQ1_N)'(sqx_reg) + (2*SQ1_N)'(sqy_reg) + (2*SQ1_N)'(sqz_reg);
        r2_reg <= (2*SQ1_N)'(sex_reg) + (2*SQ1_N)'(sey_reg) + (2*SQ1_N)'(sez_reg);
        p3_front_reg.dot <= scc_pkg::DOT_W'(px_reg) + scc_pkg::DOT_W'(py_reg)
                          + scc_pkg::DOT_W'(pz_reg);
        p3_front_reg.hidden <= p2_hid_reg;
    end

    // ---------------- distance and radius roots ----------------
    logic               s1_valid [0:SQ1_N];
    logic [FW-1:0]      s1_tag   [0:SQ1_N];
    logic [2*SQ1_N-1:0] s1_op    [0:SQ1_N][2];
    logic [SQ1_N+1:0]   s1_rem   [0:SQ1_N][2];
    logic [SQ1_N-1:0]   s1_root  [0:SQ1_N][2];

    assign s1_valid[0]   = p3_valid_reg;
    assign s1_tag[0]     = p3_front_reg;
    assign s1_op[0][0]   = d2_reg;
    assign s1_op[0][1]   = r2_reg;
    assign s1_rem[0][0]  = '0;
    assign s1_rem[0][1]  = '0;
    assign s1_root[0][0] = '0;
    assign s1_root[0][1] = '0;

    for (genvar k = 0; k < SQ1_N; k++)
    begin : g_sqrt1
        scc_sqrt_cell #(.HALF(SQ1_N), .TAG_W(FW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(s1_valid[k]), .in_tag(s1_tag[k]),
            .in_op(s1_op[k]), .in_rem(s1_rem[k]), .in_root(s1_root[k]),
            .out_valid(s1_valid[k+1]), .out_tag(s1_tag[k+1]),
            .out_op(s1_op[k+1]), .out_rem(s1_rem[k+1]), .out_root(s1_root[k+1])
        );
    end

    // ---------------- range test and divider setup ----------------
    scc_pkg::front_t              s1_front;
    logic [SQ1_N-1:0]             distance, rad;
    logic signed [SQ1_N:0]        gap;
    logic [scc_pkg::DOT_W-1:0]    dot_mag;
    logic                         p4_valid_reg;
    scc_pkg::flags_t              p4_flags_reg;
    logic [SQ1_N-1:0]             p4_dist_reg;
    logic [scc_pkg::DIVD_W-1:0]   p4_num_reg [2];

    assign s1_front = scc_pkg::front_t'(s1_tag[SQ1_N]);
    assign distance = s1_root[SQ1_N][0];
    assign rad      = s1_root[SQ1_N][1];
    assign gap      = $signed({1'b0, distance}) - $signed({1'b0, rad});
    assign dot_mag  = s1_front.dot[scc_pkg::DOT_W-1] ? scc_pkg::DOT_W'(-s1_front.dot)
                                                     : scc_pkg::DOT_W'(s1_front.dot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            p4_valid_reg <= s1_valid[SQ1_N];
        end
    end

    always_ff @(posedge clk)
    begin
        p4_flags_reg.far    <= (view_range_reg != '0)
                            && (gap > $signed({3'b0, view_range_reg}));
        p4_flags_reg.early  <= (half_cone_reg == '0) || (distance <= rad);
        p4_flags_reg.hidden <= s1_front.hidden;
        p4_flags_reg.cneg   <= s1_front.dot[scc_pkg::DOT_W-1];
        p4_dist_reg         <= distance;
        p4_num_reg[0]       <= scc_pkg::DIVD_W'(dot_mag) << 14;
        p4_num_reg[1]       <= scc_pkg::DIVD_W'(rad) << 28;
    end

    // ---------------- cosine and sine-ratio division ----------------
    logic                       dv_valid [0:DIV_N];
    logic [GW-1:0]              dv_tag   [0:DIV_N];
    logic [SQ1_N-1:0]           dv_div   [0:DIV_N];
    logic [scc_pkg::DIVD_W-1:0] dv_rem   [0:DIV_N][2];
    logic [DIV_N-1:0]           dv_quo   [0:DIV_N][2];

    assign dv_valid[0]  = p4_valid_reg;
    assign dv_tag[0]    = p4_flags_reg;
    assign dv_div[0]    = p4_dist_reg;
    assign dv_rem[0]    = p4_num_reg;
    assign dv_quo[0][0] = '0;
    assign dv_quo[0][1] = '0;

    for (genvar k = 0; k < DIV_N; k++)
    begin : g_div
        scc_div_cell #(
            .DW(scc_pkg::DIVD_W), .VW(SQ1_N), .QW(DIV_N),
            .BIT(DIV_N - 1 - k), .TAG_W(GW)
        ) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(dv_valid[k]), .in_tag(dv_tag[k]), .in_div(dv_div[k]),
            .in_rem(dv_rem[k]), .in_quo(dv_quo[k]),
            .out_valid(dv_valid[k+1]), .out_tag(dv_tag[k+1]), .out_div(dv_div[k+1]),
            .out_rem(dv_rem[k+1]), .out_quo(dv_quo[k+1])
        );
    end

    // ---------------- clamp and complement squares ----------------
    logic                        p5_valid_reg;
    scc_pkg::mid_t               p5_mid_reg;
    logic                        p6_valid_reg;
    scc_pkg::mid_t               p6_mid_reg;
    logic [2*SQ2_N-1:0]          p6_arg_reg [2];
    logic [2*scc_pkg::FRAC_W-1:0] csq, ssq;
    logic [DIV_N-1:0]            q_cos, q_sin;
    scc_pkg::flags_t             dv_flags;

    assign q_cos    = dv_quo[DIV_N][0];
    assign q_sin    = dv_quo[DIV_N][1];
    assign dv_flags = scc_pkg::flags_t'(dv_tag[DIV_N]);
    assign csq      = p5_mid_reg.cmag * p5_mid_reg.cmag;
    assign ssq      = p5_mid_reg.sval * p5_mid_reg.sval;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
        end
        else
        begin
            p5_valid_reg <= dv_valid[DIV_N];
            p6_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // a zero cosine takes the non-negative branch even for a negative dot product
        p5_mid_reg.flags <= {dv_flags.far, dv_flags.early, dv_flags.hidden,
                             dv_flags.cneg && (q_cos != '0)};
        p5_mid_reg.cmag  <= (q_cos > DIV_N'(scc_pkg::ONE_Q28)) ? scc_pkg::ONE_Q28
                                                               : q_cos[scc_pkg::FRAC_W-1:0];
        p5_mid_reg.sval  <= (q_sin > DIV_N'(scc_pkg::ONE_Q28)) ? scc_pkg::ONE_Q28
                                                               : q_sin[scc_pkg::FRAC_W-1:0];
        p6_mid_reg       <= p5_mid_reg;
        p6_arg_reg[0]    <= ((2*SQ2_N)'(1) << 56) - (2*SQ2_N)'(csq);
        p6_arg_reg[1]    <= ((2*SQ2_N)'(1) << 56) - (2*SQ2_N)'(ssq);
    end

    // ---------------- sine and cosine-partner roots ----------------
    logic               s2_valid [0:SQ2_N];
    logic [MW-1:0]      s2_tag   [0:SQ2_N];
    logic [2*SQ2_N-1:0] s2_op    [0:SQ2_N][2];
    logic [SQ2_N+1:0]   s2_rem   [0:SQ2_N][2];
    logic [SQ2_N-1:0]   s2_root  [0:SQ2_N][2];

    assign s2_valid[0]   = p6_valid_reg;
    assign s2_tag[0]     = p6_mid_reg;
    assign s2_op[0]      = p6_arg_reg;
    assign s2_rem[0][0]  = '0;
    assign s2_rem[0][1]  = '0;
    assign s2_root[0][0] = '0;
    assign s2_root[0][1] = '0;

    for (genvar k = 0; k < SQ2_N; k++)
    begin : g_sqrt2
        scc_sqrt_cell #(.HALF(SQ2_N), .TAG_W(MW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(s2_valid[k]), .in_tag(s2_tag[k]),
            .in_op(s2_op[k]), .in_rem(s2_rem[k]), .in_root(s2_root[k]),
            .out_valid(s2_valid[k+1]), .out_tag(s2_tag[k+1]),
            .out_op(s2_op[k+1]), .out_rem(s2_rem[k+1]), .out_root(s2_root[k+1])
        );
    end

    // ---------------- angle CORDIC ----------------
    scc_pkg::mid_t         s2_mid;
    logic                  cd_valid [0:ANGLE_ITERATIONS];
    logic [GW-1:0]         cd_tag   [0:ANGLE_ITERATIONS];
    logic signed [AW-1:0]  cd_x     [0:ANGLE_ITERATIONS][2];
    logic signed [AW-1:0]  cd_y     [0:ANGLE_ITERATIONS][2];
    logic signed [AW-1:0]  cd_z     [0:ANGLE_ITERATIONS][2];

    assign s2_mid      = scc_pkg::mid_t'(s2_tag[SQ2_N]);
    assign cd_valid[0] = s2_valid[SQ2_N];
    assign cd_tag[0]   = s2_mid.flags;
    assign cd_x[0][0]  = AW'(s2_mid.cmag);
    assign cd_y[0][0]  = AW'(s2_root[SQ2_N][0]);
    assign cd_x[0][1]  = AW'(s2_root[SQ2_N][1]);
    assign cd_y[0][1]  = AW'(s2_mid.sval);
    assign cd_z[0][0]  = '0;
    assign cd_z[0][1]  = '0;

    for (genvar k = 0; k < ANGLE_ITERATIONS; k++)
    begin : g_cordic
        scc_cordic_cell #(.IDX(k), .TAG_W(GW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(cd_valid[k]), .in_tag(cd_tag[k]),
            .in_x(cd_x[k]), .in_y(cd_y[k]), .in_z(cd_z[k]),
            .out_valid(cd_valid[k+1]), .out_tag(cd_tag[k+1]),
            .out_x(cd_x[k+1]), .out_y(cd_y[k+1]), .out_z(cd_z[k+1])
        );
    end

    // ---------------- cone test and result ----------------
    scc_pkg::flags_t       fin_flags;
    logic signed [AW:0]    theta;
    logic signed [AW+1:0]  diff;
    logic                  in_cone;
    logic                  done_reg, far_reg, seen_reg;

    assign fin_flags = scc_pkg::flags_t'(cd_tag[ANGLE_ITERATIONS]);
    assign theta = fin_flags.cneg
                 ? (AW+1)'(scc_pkg::PI_Q30) - (AW+1)'(cd_z[ANGLE_ITERATIONS][0])
                 : (AW+1)'(cd_z[ANGLE_ITERATIONS][0]);
    assign diff = (AW+2)'(theta) - (AW+2)'(cd_z[ANGLE_ITERATIONS][1]);
    assign in_cone = fin_flags.early
                  || (diff <= $signed({(AW+2-scc_pkg::HALF_W-16)'(0), half_cone_reg, 16'b0}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cd_valid[ANGLE_ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        far_reg  <= fin_flags.far;
        seen_reg <= !fin_flags.far && in_cone && !fin_flags.hidden;
    end

    assign done = done_reg;
    assign far  = far_reg;
    assign seen = seen_reg;

    // ---------------- checks ----------------
    a_far_not_seen: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(far && seen))
        else $error("object reported both far and seen");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        p5_valid_reg |-> (p5_mid_reg.cmag <= scc_pkg::ONE_Q28)
                      && (p5_mid_reg.sval <= scc_pkg::ONE_Q28))
        else $error("cosine or ratio escaped clamp");

    a_half_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_sel == scc_pkg::REG_HALF_CONE)
        |=> (half_cone_reg == $past(pwdata[15:0])))
        else $error("half cone register write lost");

    a_range_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_sel == scc_pkg::REG_VIEW_RANGE)
        |=> (view_range_reg == $past(pwdata[30:0])))
        else $error("view range register write lost");

endmodule
